/* hw/rtl/pdds_pkg.sv */
package pdds_pkg;

  parameter int POS_WIDTH_DEF      = 24;
  parameter int GAIN_FRAC_BITS_DEF = 8;

  parameter int GAIN_W  = 16;
  parameter int TGT_W   = 21;
  parameter int TOL_W   = 16;
  parameter int ERR_W   = 26;
  parameter int SUM_W   = 40;
  parameter int DRIVE_W = 15;
  parameter int CFG_W   = 21;
  parameter int IDX_W   = 3;

  // move distance to encoder units: wheel circumference over 360 as 2359/65536
  parameter int DIST_SCALE_NUM   = 2359;
  parameter int DIST_SCALE_NUM_W = 13;
  parameter int DIST_SCALE_SHIFT = 16;
  parameter int TPROD_W          = TGT_W + DIST_SCALE_NUM_W;
  parameter int TGT_SCALED_W     = TPROD_W - DIST_SCALE_SHIFT;

  parameter int DRIVE_LIMIT = 12000;

  parameter int DERIV_W  = ERR_W + 1;
  parameter int SUM_LO_W = 20;
  parameter int PTERM_W  = GAIN_W + ERR_W;
  parameter int DTERM_W  = GAIN_W + DERIV_W;
  parameter int ILO_W    = GAIN_W + SUM_LO_W + 1;
  parameter int IHI_W    = GAIN_W + SUM_W - SUM_LO_W;
  parameter int ACC_W    = GAIN_W + SUM_W + 1;

  parameter int OUT_DATA_W = ((DRIVE_W + ERR_W + 7) / 8) * 8;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_TARGET_DIST = 3'd3,
    REG_STOP_TOL    = 3'd4
  } cfg_reg_t;

  // registered partial products of the three gain terms
  typedef struct packed {
    logic signed [PTERM_W-1:0] p_term;
    logic signed [DTERM_W-1:0] d_term;
    logic signed [ILO_W-1:0]   i_lo;
    logic signed [IHI_W-1:0]   i_hi;
  } prod_t;

endpackage

/* hw/rtl/pdds_err_calc.sv */
module pdds_err_calc #(
  parameter int POS_WIDTH = pdds_pkg::POS_WIDTH_DEF
) (
  input  logic signed [POS_WIDTH-1:0]              pos_back_left,
  input  logic signed [POS_WIDTH-1:0]              pos_back_right,
  input  logic signed [POS_WIDTH-1:0]              pos_front_left,
  input  logic signed [POS_WIDTH-1:0]              pos_front_right,
  input  logic signed [pdds_pkg::TGT_SCALED_W-1:0] target,
  output logic signed [pdds_pkg::ERR_W-1:0]        err
);

  localparam int TOT_W  = POS_WIDTH + 2;
  localparam int DIFF_W = ((POS_WIDTH > pdds_pkg::TGT_SCALED_W) ?
                           POS_WIDTH : pdds_pkg::TGT_SCALED_W) + 1;
  localparam int CMP_W  = (DIFF_W > pdds_pkg::ERR_W) ? DIFF_W : pdds_pkg::ERR_W;
  localparam logic signed [CMP_W-1:0] ERR_MAX_X =
    {{(CMP_W - pdds_pkg::ERR_W + 1){1'b0}}, {(pdds_pkg::ERR_W - 1){1'b1}}};
  localparam logic signed [CMP_W-1:0] ERR_MIN_X =
    {{(CMP_W - pdds_pkg::ERR_W + 1){1'b1}}, {(pdds_pkg::ERR_W - 1){1'b0}}};

  logic signed [TOT_W-1:0]     total;
  logic signed [POS_WIDTH-1:0] position;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [CMP_W-1:0]     diff_x;
  logic signed [CMP_W-1:0]     clamped;

  always_comb begin
    total = TOT_W'(pos_back_left) + TOT_W'(pos_back_right) +
            TOT_W'(pos_front_left) + TOT_W'(pos_front_right);
    // dropping two low bits of a signed sum is the floor of sum / 4
    position = total[TOT_W-1:2];
    diff     = DIFF_W'(target) - DIFF_W'(position);
    diff_x   = CMP_W'(diff);
    if (diff_x > ERR_MAX_X) begin
      clamped = ERR_MAX_X;
    end else if (diff_x < ERR_MIN_X) begin
      clamped = ERR_MIN_X;
    end else begin
      clamped = diff_x;
    end
    err = clamped[pdds_pkg::ERR_W-1:0];
  end

endmodule

/* hw/rtl/pdds_drive_sum.sv */
module pdds_drive_sum #(
  parameter int GAIN_FRAC_BITS = pdds_pkg::GAIN_FRAC_BITS_DEF
) (
  input  pdds_pkg::prod_t                      prod,
  output logic signed [pdds_pkg::DRIVE_W-1:0] drive
);

  localparam int ACC_W = pdds_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(pdds_pkg::DRIVE_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] clamped;

  always_comb begin
    // integral product rebuilt from its high and low halves
    acc = ACC_W'(prod.p_term) + ACC_W'(prod.d_term) + ACC_W'(prod.i_lo) +
          (ACC_W'(prod.i_hi) <<< pdds_pkg::SUM_LO_W);
    shifted = acc >>> GAIN_FRAC_BITS;
    if (shifted > LIM_HI) begin
      clamped = LIM_HI;
    end else if (shifted < LIM_LO) begin
      clamped = LIM_LO;
    end else begin
      clamped = shifted;
    end
    drive = clamped[pdds_pkg::DRIVE_W-1:0];
  end

endmodule

/* hw/rtl/pid_drive_distance_step_unit.sv */
// pipeline: 5 register stages, one request per cycle unless out_tready stalls it;
//   the integral and previous-error feedback is a single add and clamp in one stage,
//   the gain products are split over two stages
// reset: rst_n synchronous active low; clears all config registers, integral and previous
//   error to zero and empties the pipeline
module pid_drive_distance_step_unit #(
  parameter int POS_WIDTH      = pdds_pkg::POS_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pdds_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [pdds_pkg::IDX_W-1:0]               cfg_index,
  input  logic [pdds_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // pos_back_left, pos_back_right, pos_front_left, pos_front_right, zero pad
  input  logic [((4*POS_WIDTH+7)/8)*8-1:0]         in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // drive_millivolts [14:0], position_error [40:15], zero pad
  output logic [pdds_pkg::OUT_DATA_W-1:0]          out_tdata,
  // move_done
  output logic                                     out_tuser
);

  localparam int ERR_W   = pdds_pkg::ERR_W;
  localparam int SUM_W   = pdds_pkg::SUM_W;
  localparam int SUMX_W  = SUM_W + 1;
  localparam int DERIV_W = pdds_pkg::DERIV_W;
  localparam int LO_W    = pdds_pkg::SUM_LO_W;
  localparam int TPROD_W = pdds_pkg::TPROD_W;
  localparam int DRIVE_W = pdds_pkg::DRIVE_W;
  localparam int PAD_W   = pdds_pkg::OUT_DATA_W - DRIVE_W - ERR_W;
  localparam logic signed [TPROD_W-1:0] SCALE_NUM = TPROD_W'(pdds_pkg::DIST_SCALE_NUM);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration
  logic signed [pdds_pkg::GAIN_W-1:0]       gain_p_r, gain_i_r, gain_d_r;
  logic signed [pdds_pkg::TGT_W-1:0]        target_dist_r;
  logic [pdds_pkg::TOL_W-1:0]               stop_tol_r;
  logic signed [pdds_pkg::TGT_SCALED_W-1:0] target_r;
  logic signed [TPROD_W-1:0]                tprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      target_dist_r <= '0;
      stop_tol_r    <= '0;
    end else if (cfg_we) begin
      case (pdds_pkg::cfg_reg_t'(cfg_index))
        pdds_pkg::REG_GAIN_P:      gain_p_r      <= cfg_data[pdds_pkg::GAIN_W-1:0];
        pdds_pkg::REG_GAIN_I:      gain_i_r      <= cfg_data[pdds_pkg::GAIN_W-1:0];
        pdds_pkg::REG_GAIN_D:      gain_d_r      <= cfg_data[pdds_pkg::GAIN_W-1:0];
        pdds_pkg::REG_TARGET_DIST: target_dist_r <= cfg_data[pdds_pkg::TGT_W-1:0];
        pdds_pkg::REG_STOP_TOL:    stop_tol_r    <= cfg_data[pdds_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // scaled target, floor of the product by 2^16
  assign tprod = TPROD_W'(target_dist_r) * SCALE_NUM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else begin
      target_r <= tprod[TPROD_W-1:pdds_pkg::DIST_SCALE_SHIFT];
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy2, rdy3, rdy4, rdy_out;
  logic ld1, ld2, ld3, ld4, ld_out;

  assign rdy_out   = !vo_r || out_tready;
  assign rdy4      = !v4_r || rdy_out;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign in_tready = !v1_r || rdy2;
  assign ld1       = in_tvalid && in_tready;
  assign ld2       = v1_r && rdy2;
  assign ld3       = v2_r && rdy3;
  assign ld4       = v3_r && rdy4;
  assign ld_out    = v4_r && rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (in_tready) v1_r <= in_tvalid;
      if (rdy2)      v2_r <= v1_r;
      if (rdy3)      v3_r <= v2_r;
      if (rdy4)      v4_r <= v3_r;
      if (rdy_out)   vo_r <= v4_r;
    end
  end

  // stage 1: input capture
  logic signed [POS_WIDTH-1:0] pos_bl_r, pos_br_r, pos_fl_r, pos_fr_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      pos_bl_r <= in_tdata[POS_WIDTH-1:0];
      pos_br_r <= in_tdata[2*POS_WIDTH-1:POS_WIDTH];
      pos_fl_r <= in_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
      pos_fr_r <= in_tdata[4*POS_WIDTH-1:3*POS_WIDTH];
    end
  end

  // stage 2: averaged position and error
  logic signed [ERR_W-1:0] err_s1;
  logic signed [ERR_W-1:0] err2_r;

  pdds_err_calc #(
    .POS_WIDTH(POS_WIDTH)
  ) u_err_calc (
    .pos_back_left  (pos_bl_r),
    .pos_back_right (pos_br_r),
    .pos_front_left (pos_fl_r),
    .pos_front_right(pos_fr_r),
    .target         (target_r),
    .err            (err_s1)
  );

  always_ff @(posedge clk) begin
    if (ld2) begin
      err2_r <= err_s1;
    end
  end

  // stage 3: derivative, integral and tolerance check
  logic signed [SUM_W-1:0]   error_sum_r;
  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [SUMX_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [DERIV_W-1:0] deriv;
  logic [ERR_W-1:0]          mag;
  logic                      done_s2;
  logic signed [ERR_W-1:0]   err3_r;
  logic signed [DERIV_W-1:0] deriv3_r;
  logic signed [SUM_W-1:0]   sum3_r;
  logic                      done3_r;

  always_comb begin
    sum_x = SUMX_W'(error_sum_r) + SUMX_W'(err2_r);
    if (sum_x[SUMX_W-1] != sum_x[SUM_W-1]) begin
      sum_nxt = sum_x[SUMX_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_x[SUM_W-1:0];
    end
    deriv   = DERIV_W'(err2_r) - DERIV_W'(last_error_r);
    mag     = err2_r[ERR_W-1] ? ERR_W'(-err2_r) : ERR_W'(err2_r);
    done_s2 = (mag <= ERR_W'(stop_tol_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (ld3) begin
      error_sum_r  <= sum_nxt;
      last_error_r <= err2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      err3_r   <= err2_r;
      deriv3_r <= deriv;
      sum3_r   <= sum_nxt;
      done3_r  <= done_s2;
    end
  end

  // stage 4: gain products, integral split into two halves
  pdds_pkg::prod_t         prod_nxt;
  pdds_pkg::prod_t         prod4_r;
  logic signed [ERR_W-1:0] err4_r;
  logic                    done4_r;

  always_comb begin
    prod_nxt.p_term = gain_p_r * err3_r;
    prod_nxt.d_term = gain_d_r * deriv3_r;
    prod_nxt.i_lo   = gain_i_r * $signed({1'b0, sum3_r[LO_W-1:0]});
    prod_nxt.i_hi   = gain_i_r * $signed(sum3_r[SUM_W-1:LO_W]);
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      prod4_r <= prod_nxt;
      err4_r  <= err3_r;
      done4_r <= done3_r;
    end
  end

  // output stage: sum, shift, clamp
  logic signed [DRIVE_W-1:0] drive_s4;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [ERR_W-1:0]   err_out_r;
  logic                      done_out_r;

  pdds_drive_sum #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_drive_sum (
    .prod (prod4_r),
    .drive(drive_s4)
  );

  always_ff @(posedge clk) begin
    if (ld_out) begin
      drive_r    <= drive_s4;
      err_out_r  <= err4_r;
      done_out_r <= done4_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {{PAD_W{1'b0}}, err_out_r, drive_r};
  assign out_tuser  = done_out_r;

  // checks
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> ($stable(error_sum_r) && $stable(last_error_r)))
    else $error("integral or previous error changed while stage stalled");

  a_last_err: assert property (@(posedge clk) disable iff (!rst_n)
    ld3 |=> (last_error_r == $past(err2_r)))
    else $error("previous error not taken from advancing request");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> ((drive_r <= DRIVE_W'(pdds_pkg::DRIVE_LIMIT)) &&
              (drive_r >= -DRIVE_W'(pdds_pkg::DRIVE_LIMIT))))
    else $error("drive outside limit");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && vo_r && !out_tready))
    else $error("input stalled with room in pipeline");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int POS_W = pdds_pkg::POS_WIDTH_DEF;
  localparam int IN_W  = ((4 * POS_W + 7) / 8) * 8;

  localparam int IDX_W            = pdds_pkg::IDX_W;
  localparam int GAIN_W           = pdds_pkg::GAIN_W;
  localparam int TGT_W            = pdds_pkg::TGT_W;
  localparam int TOL_W            = pdds_pkg::TOL_W;
  localparam int ERR_W            = pdds_pkg::ERR_W;
  localparam int SUM_W            = pdds_pkg::SUM_W;
  localparam int DRIVE_W          = pdds_pkg::DRIVE_W;
  localparam int CFG_W            = pdds_pkg::CFG_W;
  localparam int OUT_DATA_W       = pdds_pkg::OUT_DATA_W;
  localparam int DIST_SCALE_SHIFT = pdds_pkg::DIST_SCALE_SHIFT;
  localparam int GAIN_FRAC_BITS   = pdds_pkg::GAIN_FRAC_BITS_DEF;
  localparam longint DIST_SCALE_NUM = longint'(pdds_pkg::DIST_SCALE_NUM);
  localparam longint DRIVE_LIMIT    = longint'(pdds_pkg::DRIVE_LIMIT);

  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 16'h7fff;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 16'h8000;
  localparam logic [TGT_W-1:0]  TGT_MAX  = 21'h0fffff;
  localparam logic [TGT_W-1:0]  TGT_MIN  = 21'h100000;
  localparam logic [TOL_W-1:0]  TOL_MAX  = 16'hffff;

  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
  localparam longint ERR_MAX = (longint'(1) << (ERR_W - 1)) - 1;
  localparam longint ERR_MIN = -(longint'(1) << (ERR_W - 1));
  localparam longint SUM_MAX = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) << (SUM_W - 1));

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done;
    logic signed [ERR_W-1:0]   err;
  } tick_res_t;

  typedef struct {
    int  p[4];
    bit  typed;
    int  err;
    bit  done;
  } tick_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic               out_tuser;

  // controller copy: configuration and loop state
  longint k_p, k_i, k_d, k_target, k_tol;
  longint integ, prev_err;

  tick_res_t drive_q[$];
  tick_row_t tick_rows[$];
  int        reqs_taken = 0;
  int        errors = 0;
  bit        calm = 1'b0;
  bit        busy = 1'b0;
  bit        hand_valid = 1'b0;
  tick_res_t hand_res;
  int        stall_left = 0;

  tick_res_t                 want;
  logic signed [DRIVE_W-1:0] got_drive;
  logic signed [ERR_W-1:0]   got_err;
  logic                      got_done;

  pid_drive_distance_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // move distance in encoder units
  function automatic longint enc_target();
    return (k_target * DIST_SCALE_NUM) >>> DIST_SCALE_SHIFT;
  endfunction

  function automatic tick_res_t pid_tick(input logic [IN_W-1:0] d);
    longint total, e, u, mag;
    tick_res_t r;
    total = 0;
    for (int k = 0; k < 4; k++) total += longint'($signed(d[k*POS_W +: POS_W]));
    e = sat(enc_target() - (total >>> 2), ERR_MIN, ERR_MAX);
    integ = sat(integ + e, SUM_MIN, SUM_MAX);
    u = k_p * e + k_i * integ + k_d * (e - prev_err);
    u = sat(u >>> GAIN_FRAC_BITS, -DRIVE_LIMIT, DRIVE_LIMIT);
    prev_err = e;
    mag = (e < 0) ? -e : e;
    r.drive = DRIVE_W'(u);
    r.err = ERR_W'(e);
    r.done = (mag <= k_tol);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (busy) return (r == 0) ? 1 : 0;
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic note_bad(input string what, input longint exp_v, input longint got_v);
    if (errors < 10) $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    errors++;
  endtask

  // check results, then predict the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_drive = out_tdata[DRIVE_W-1:0];
        got_err = out_tdata[DRIVE_W +: ERR_W];
        got_done = out_tuser;
        if (drive_q.size() == 0) begin
          note_bad("result with no request pending, drive", 0, got_drive);
        end else begin
          want = drive_q.pop_front();
          if (got_drive !== want.drive) note_bad("drive_millivolts", want.drive, got_drive);
          if (got_err !== want.err) note_bad("position_error", want.err, got_err);
          if (got_done !== want.done) note_bad("move_done", want.done, got_done);
        end
      end
      if (in_tvalid && in_tready) begin
        want = pid_tick(in_tdata);
        drive_q.push_back(hand_valid ? hand_res : want);
        hand_valid = 1'b0;
        reqs_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pdds_pkg::REG_GAIN_P:      k_p = $signed(val[GAIN_W-1:0]);
      pdds_pkg::REG_GAIN_I:      k_i = $signed(val[GAIN_W-1:0]);
      pdds_pkg::REG_GAIN_D:      k_d = $signed(val[GAIN_W-1:0]);
      pdds_pkg::REG_TARGET_DIST: k_target = $signed(val[TGT_W-1:0]);
      pdds_pkg::REG_STOP_TOL:    k_tol = val[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_item(input logic [IN_W-1:0] d);
    int g, n;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    n = reqs_taken;
    do @(negedge clk); while (reqs_taken == n);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (drive_q.size() != 0);
  endtask

  task automatic add_row(input int bl, input int br, input int fl, input int fr,
                         input bit typed = 1'b0, input int err = 0, input bit done = 1'b0);
    tick_row_t r;
    r.p[0] = bl;
    r.p[1] = br;
    r.p[2] = fl;
    r.p[3] = fr;
    r.typed = typed;
    r.err = err;
    r.done = done;
    tick_rows.push_back(r);
  endtask

  task automatic run_rows(input bit use_typed);
    foreach (tick_rows[i]) begin
      hand_valid = use_typed && tick_rows[i].typed;
      hand_res.drive = '0;
      hand_res.err = ERR_W'(tick_rows[i].err);
      hand_res.done = tick_rows[i].done;
      send_item({POS_W'(tick_rows[i].p[3]), POS_W'(tick_rows[i].p[2]),
                 POS_W'(tick_rows[i].p[1]), POS_W'(tick_rows[i].p[0])});
    end
  endtask

  function automatic logic [CFG_W-1:0] rand_gain();
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom);
    case ($urandom_range(3))
      0: v[GAIN_W-1:0] = GAIN_W'(int'($urandom_range(512)) - 256);
      1: v[GAIN_W-1:0] = GAIN_W'(int'($urandom_range(8192)) - 4096);
      2: ;
      default: v[GAIN_W-1:0] = $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
    endcase
    return v;
  endfunction

  task automatic random_setup(input bool_mins);
    logic [CFG_W-1:0] v;
    if (bool_mins) begin
      write_reg(pdds_pkg::REG_GAIN_P, {5'h1f, GAIN_MIN});
      write_reg(pdds_pkg::REG_GAIN_I, {5'h1f, GAIN_MIN});
      write_reg(pdds_pkg::REG_GAIN_D, {5'h1f, GAIN_MIN});
      write_reg(pdds_pkg::REG_TARGET_DIST, TGT_MIN);
      write_reg(pdds_pkg::REG_STOP_TOL, '0);
    end else begin
      write_reg(pdds_pkg::REG_GAIN_P, rand_gain());
      write_reg(pdds_pkg::REG_GAIN_I, rand_gain());
      write_reg(pdds_pkg::REG_GAIN_D, rand_gain());
      v = CFG_W'($urandom);
      case ($urandom_range(3))
        0: v = $urandom_range(1) ? TGT_MAX : TGT_MIN;
        1: v = CFG_W'(int'($urandom_range(4000)) - 2000);
        default: ;
      endcase
      write_reg(pdds_pkg::REG_TARGET_DIST, v);
      v = CFG_W'($urandom);
      case ($urandom_range(3))
        0: v = '0;
        1: v = {5'h0, TOL_MAX};
        2: v = CFG_W'($urandom_range(64));
        default: ;
      endcase
      write_reg(pdds_pkg::REG_STOP_TOL, v);
    end
    write_reg(IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), CFG_W'($urandom));
  endtask

  function automatic logic [IN_W-1:0] random_ticks();
    logic [IN_W-1:0] d;
    longint base, noise;
    int mode, sh;
    d = '0;
    base = enc_target();
    mode = $urandom_range(99);
    for (int k = 0; k < 4; k++) begin
      sh = $urandom_range(12);
      noise = longint'($urandom_range(2 ** (sh + 1))) - (longint'(1) << sh);
      if (mode < 60) begin
        d[k*POS_W +: POS_W] = POS_W'(base + noise);
      end else if (mode < 85) begin
        d[k*POS_W +: POS_W] = POS_W'($urandom);
      end else begin
        case ($urandom_range(3))
          0: d[k*POS_W +: POS_W] = POS_W'(POS_MAX);
          1: d[k*POS_W +: POS_W] = POS_W'(POS_MIN);
          2: d[k*POS_W +: POS_W] = '0;
          default: d[k*POS_W +: POS_W] = '1;
        endcase
      end
    end
    return d;
  endfunction

  // drive the integral toward goal with the largest error steps the encoders allow,
  // then hold it there for hold more requests
  task automatic steer_integral(input longint goal, input int hold);
    longint p, reach;
    int held;
    held = 0;
    reach = sat(goal, SUM_MIN, SUM_MAX);
    while (held < hold) begin
      p = sat(enc_target() - (goal - integ), POS_MIN, POS_MAX);
      send_item({4{POS_W'(p)}});
      if (integ == reach) held++;
    end
  endtask

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    k_p = 0; k_i = 0; k_d = 0; k_target = 0; k_tol = 0;
    integ = 0; prev_err = 0;

    // with everything at reset only the error and the exact-zero done flag move
    add_row(0, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(int'(POS_MAX), int'(POS_MAX), int'(POS_MAX), int'(POS_MAX), 1'b1, -8388607, 1'b0);
    add_row(int'(POS_MIN), int'(POS_MIN), int'(POS_MIN), int'(POS_MIN), 1'b1, 8388608, 1'b0);
    add_row(-1, 0, 0, 0, 1'b1, 1, 1'b0);
    add_row(3, 0, 0, 0, 1'b1, 0, 1'b1);
    add_row(int'(POS_MAX), int'(POS_MIN), int'(POS_MAX), int'(POS_MIN), 1'b1, 1, 1'b0);
    add_row(100, 200, 300, 400, 1'b1, -250, 1'b0);
    add_row(-100, -200, -300, -401, 1'b1, 251, 1'b0);
    add_row(-4, -4, -4, -5, 1'b1, 5, 1'b0);
    add_row(32'h00555555, 32'h00aaaaaa, 32'h00555555, 32'h00aaaaaa);
    add_row(32'h00123456, 32'h00fedcba, 32'h007f0000, 32'h0080ffff);
    add_row(1, -1, int'(POS_MAX), int'(POS_MIN));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_rows(1'b1);
    wait_idle();

    write_reg(pdds_pkg::REG_GAIN_P, {5'h0, GAIN_MAX});
    write_reg(pdds_pkg::REG_GAIN_I, {5'h0, GAIN_MIN});
    write_reg(pdds_pkg::REG_GAIN_D, {5'h0, GAIN_MAX});
    write_reg(pdds_pkg::REG_TARGET_DIST, TGT_MAX);
    write_reg(pdds_pkg::REG_STOP_TOL, {5'h0, TOL_MAX});
    run_rows(1'b0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      random_setup(ph == 0);
      calm = ($urandom_range(3) == 0);
      repeat (50) send_item(random_ticks());
      wait_idle();
    end

    // large integral in both directions, with a landing in between where the
    // integral term shows in the drive exactly
    calm = 1'b0;
    write_reg(pdds_pkg::REG_GAIN_P, 21'h000040);
    write_reg(pdds_pkg::REG_GAIN_I, 21'd300);
    write_reg(pdds_pkg::REG_GAIN_D, 21'h000020);
    write_reg(pdds_pkg::REG_TARGET_DIST, TGT_MAX);
    write_reg(pdds_pkg::REG_STOP_TOL, CFG_W'($urandom_range(64)));
    busy = 1'b1;
    steer_integral(100_000_000, 4);
    steer_integral(-1500, 4);
    steer_integral(-100_000_000, 4);
    busy = 1'b0;

    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
